@@ hdl/lphs_pkg.sv @@
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared types and constants for the linear-probing hash set.
// ----------------------------------------------------------------------------
package lphs_pkg;

   // Table geometry. The table size must be a power of two. The home slot
   // is then the low address bits of the key, which is already the
   // non-negative remainder.
   localparam int TableSize = 4096;
   localparam int AddrW     = $clog2(TableSize);
   localparam int KeyW      = 32;
   localparam int SlotW     = 12;
   localparam int EntryW    = KeyW + 1;

   // Request codes.
   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_QUERY  = 1'b1
   } req_kind_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // take a new request and start at its home slot
      logic advance;  // step the probe to the next slot
      logic finish;   // capture the response and commit an insert
      logic clear;    // write one empty entry during the clearing pass
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;      // the current slot holds the key
      logic empty;    // the current slot is unoccupied
      logic last;     // probe counter (or clear pointer) is at its end
   } status_type;

endpackage

@@ hdl/lphs_ram.sv @@
// ----------------------------------------------------------------------------
// lphs_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module lphs_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ hdl/lphs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lphs_ctrl
// Controller: runs the clearing pass, takes requests, steps the probe and
// owns the response valid flag.
// ----------------------------------------------------------------------------
module lphs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  lphs_pkg::status_type   status,
   output lphs_pkg::cmd_type      cmd
);
   import lphs_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;
   logic      done;

   // The response register can take a new transaction when it is empty or
   // being emptied this cycle.
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign done     = status.hit || status.empty || status.last;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (done && rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_PROBE: begin
            cmd.finish  = done && rsp_free;
            cmd.advance = !done;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Response valid flag.
   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/lphs_dpath.sv @@
// ----------------------------------------------------------------------------
// lphs_dpath
// Datapath: request registers, probe pointer and counter, the slot table
// and the response register.
// ----------------------------------------------------------------------------
module lphs_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lphs_pkg::cmd_type                    cmd,
   output lphs_pkg::status_type                 status,
   input  logic                                 req_type,
   input  logic signed [lphs_pkg::KeyW-1:0]     req_key,
   output logic                                 rsp_present,
   output logic        [lphs_pkg::SlotW-1:0]    rsp_slot,
   output logic                                 rsp_full_res
);
   import lphs_pkg::*;

   logic [KeyW-1:0]   key_ff;
   req_kind_type      kind_ff;
   logic [AddrW-1:0]  probe_ff, probe_in;
   logic [AddrW-1:0]  count_ff, count_in;
   logic [AddrW-1:0]  rd_addr;
   logic [AddrW-1:0]  wr_addr;
   logic [EntryW-1:0] wr_data;
   logic [EntryW-1:0] rd_data;
   logic              wr_en;
   logic              entry_valid;
   logic              is_full;

   // The entry read back belongs to the slot held in probe_ff.
   assign entry_valid  = rd_data[KeyW];
   assign status.empty = !entry_valid;
   assign status.hit   = entry_valid && (rd_data[KeyW-1:0] == key_ff);
   assign status.last  = (count_ff == AddrW'(TableSize - 1));
   assign is_full      = !status.hit && !status.empty;

   // Probe pointer and counter. The counter doubles as the clear pointer.
   always_comb begin
      probe_in = probe_ff;
      count_in = count_ff;
      if (cmd.load) begin
         probe_in = req_key[AddrW-1:0];
         count_in = '0;
      end else if (cmd.advance) begin
         probe_in = probe_ff + AddrW'(1);
         count_in = count_ff + AddrW'(1);
      end else if (cmd.clear) begin
         count_in = count_ff + AddrW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff <= probe_in;
      if (cmd.load) begin
         key_ff  <= req_key;
         kind_ff <= req_kind_type'(req_type);
      end
   end

   // Read the slot the probe moves to next, so one slot is checked per cycle.
   assign rd_addr = probe_in;

   // Writes: empty entries during clearing, the key on a successful insert.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = probe_ff;
      wr_data = {1'b1, key_ff};
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = count_ff;
         wr_data = '0;
      end else if (cmd.finish && status.empty && kind_ff == REQ_INSERT) begin
         wr_en = 1'b1;
      end
   end

   lphs_ram #(
      .Width (EntryW),
      .Depth (TableSize)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_present  <= status.hit;
         rsp_full_res <= is_full;
         rsp_slot     <= is_full ? '0 : SlotW'(probe_ff);
      end
   end

endmodule

@@ hdl/linear_probe_hash_set_top.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_set_top
// Hash set of signed 32-bit keys with insert and query by linear probing.
// ----------------------------------------------------------------------------
// After reset the block clears its 4096-entry table, one entry per cycle, so
// req_ready stays low until the clearing pass ends. Each transaction is then
// loaded and probes at least one slot; the table RAM is read once per probed
// slot. One request is in flight at a time, and a new one may be taken while
// the previous response waits on rsp_ready.
// A probe that visits every slot without a match or a free slot reports
// rsp_full_res with slot 0 and drops an insert.
module linear_probe_hash_set_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic signed [lphs_pkg::KeyW-1:0]     req_key,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_present,
   output logic        [lphs_pkg::SlotW-1:0]    rsp_slot,
   output logic                                 rsp_full_res
);
   import lphs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Controller.
   lphs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   lphs_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_type     (req_type),
      .req_key      (req_key),
      .rsp_present  (rsp_present),
      .rsp_slot     (rsp_slot),
      .rsp_full_res (rsp_full_res)
   );

endmodule

@@ hdl/lphs_checker.sv @@
// ----------------------------------------------------------------------------
// lphs_checker
// Port-level checks for the hash set, bound to the top level.
// ----------------------------------------------------------------------------
module lphs_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 req_type,
   input logic signed [lphs_pkg::KeyW-1:0]     req_key,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_present,
   input logic        [lphs_pkg::SlotW-1:0]    rsp_slot,
   input logic                                 rsp_full_res
);
   import lphs_pkg::*;

   // Coming out of reset the table is being cleared and nothing is pending.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("requests taken or response shown right after reset");

   // Only one request is worked on at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is being probed");

   // A full result never claims the key and always reports slot zero.
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_full_res) |-> (!rsp_present && rsp_slot == '0))
      else $error("inconsistent full-table response");

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_present) && $stable(rsp_slot)
          && $stable(rsp_full_res)))
      else $error("stalled response changed");

endmodule

bind linear_probe_hash_set_top lphs_checker u_lphs_checker (.*);
